// File: rtl/sim_pkg.sv
// Shared types and constants for the speed interval map.
// Depends on nothing; used by the channel interfaces, the cell and the top level.
`timescale 1ns / 1ps

package sim_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 24;
   localparam int SPD_W  = 16;
   localparam int IDX_W  = 8;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   localparam logic [IDX_W-1:0] NONE_INDEX = 8'd255;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [SPD_W-1:0] spd;
   } wr_type;

   typedef struct packed {
      logic             live;
      logic             is_find;
      logic [POS_W-1:0] position;
      logic [IDX_W-1:0] index;
      logic             hit;
      logic [IDX_W-1:0] found_index;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [SPD_W-1:0] spd;
   } tok_type;

   typedef struct packed {
      logic [IDX_W-1:0]  found_index;
      logic [POS_W-1:0]  start_position;
      logic [POS_W-1:0]  end_position;
      logic [SPD_W-1:0]  interval_speed;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

// File: rtl/sim_chan_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on sim_pkg for field widths.
`timescale 1ns / 1ps

interface sim_req_if;
   logic                       valid;
   logic                       ready;
   logic [sim_pkg::OP_W-1:0]   opcode;
   logic [sim_pkg::POS_W-1:0]  position;
   logic [sim_pkg::SPD_W-1:0]  speed_limit;
   logic [sim_pkg::IDX_W-1:0]  index;

   modport source (output valid, opcode, position, speed_limit, index, input ready);
   modport sink   (input valid, opcode, position, speed_limit, index, output ready);
endinterface

interface sim_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sim_pkg::IDX_W-1:0]  found_index;
   logic [sim_pkg::POS_W-1:0]  start_position;
   logic [sim_pkg::POS_W-1:0]  end_position;
   logic [sim_pkg::SPD_W-1:0]  interval_speed;
   logic [sim_pkg::STAT_W-1:0] status;

   modport source (output valid, found_index, start_position, end_position,
                   interval_speed, status, input ready);
   modport sink   (input valid, found_index, start_position, end_position,
                   interval_speed, status, output ready);
endinterface

// File: rtl/speed_interval_map.sv
// Top level of the speed interval map: run tracking, store control and the row of cells.
// Depends on sim_pkg, sim_chan_if and sim_cell.
//
//   channel   port      direction   word
//   request   req_in    in          opcode, position, speed_limit, index
//   response  rsp_out   out         found_index, start/end_position, interval_speed, status
//
// Clear, add point, close and unused codes: the response is registered from the accepted word.
// Find and read: the token walks the row, one cell per cycle, into the response register.
// One word is in work at a time; a waiting response holds off the next request.
// Reset is synchronous; stored intervals need no clearing pass, the count gates them.
`timescale 1ns / 1ps

module speed_interval_map #(
   parameter int MAX_INTERVALS = 64
) (
   input  logic       clock,
   input  logic       reset,
   sim_req_if.sink    req_in,
   sim_rsp_if.source  rsp_out
);
   import sim_pkg::*;

   localparam int COUNT_W = $clog2(MAX_INTERVALS + 1);

   state_type          state_ff;
   state_type          state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [POS_W-1:0]   run_start_ff;
   logic [POS_W-1:0]   run_start_in;
   logic [SPD_W-1:0]   run_speed_ff;
   logic [SPD_W-1:0]   run_speed_in;
   logic [POS_W-1:0]   prev_pos_ff;
   logic [POS_W-1:0]   prev_pos_in;
   logic               run_open_ff;
   logic               run_open_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               req_acc;
   logic               scan_go;
   logic               full;
   wr_type             store_wr;
   wr_type             wr;
   rsp_type            store_res;
   rsp_type            res;
   tok_type            tok [MAX_INTERVALS+1];
   tok_type            tail;

   assign req_acc = req_in.valid && req_in.ready;
   assign tail    = tok[MAX_INTERVALS];

   // row of cells
   for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
      sim_cell #(
         .CELL_ID (k),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_i    (wr),
         .count_i (count_ff),
         .tok_i   (tok[k]),
         .tok_o   (tok[k+1])
      );
   end

   // store of the open run
   always_comb begin
      full                     = count_ff == COUNT_W'(MAX_INTERVALS);
      store_wr.we              = !full;
      store_wr.addr            = IDX_W'(count_ff);
      store_wr.lo              = run_start_ff;
      store_wr.hi              = prev_pos_ff;
      store_wr.spd             = run_speed_ff;
      store_res.found_index    = full ? NONE_INDEX : IDX_W'(count_ff);
      store_res.start_position = full ? '0 : run_start_ff;
      store_res.end_position   = full ? '0 : prev_pos_ff;
      store_res.interval_speed = full ? '0 : run_speed_ff;
      store_res.status         = full ? STAT_FULL : STAT_OK;
   end

   always_comb begin
      count_in     = count_ff;
      run_start_in = run_start_ff;
      run_speed_in = run_speed_ff;
      prev_pos_in  = prev_pos_ff;
      run_open_in  = run_open_ff;
      wr           = store_wr;
      wr.we        = 1'b0;
      res          = '{found_index: NONE_INDEX, start_position: '0, end_position: '0,
                       interval_speed: '0, status: STAT_OK};
      scan_go      = 1'b0;
      if (req_acc) begin
         case (req_in.opcode)
            OP_CLEAR: begin
               count_in    = '0;
               run_open_in = 1'b0;
            end
            OP_ADD: begin
               if (run_open_ff && req_in.speed_limit != run_speed_ff) begin
                  wr           = store_wr;
                  res          = store_res;
                  count_in     = full ? count_ff : count_ff + COUNT_W'(1);
                  run_start_in = req_in.position;
                  run_speed_in = req_in.speed_limit;
               end else if (!run_open_ff) begin
                  run_start_in = req_in.position;
                  run_speed_in = req_in.speed_limit;
                  run_open_in  = 1'b1;
               end
               prev_pos_in = req_in.position;
            end
            OP_CLOSE: begin
               if (run_open_ff) begin
                  wr          = store_wr;
                  res         = store_res;
                  count_in    = full ? count_ff : count_ff + COUNT_W'(1);
                  run_open_in = 1'b0;
               end else begin
                  res.status = STAT_MISS;
               end
            end
            OP_FIND, OP_READ: begin
               scan_go = 1'b1;
            end
            default: begin
               res.status = STAT_MISS;
            end
         endcase
      end
   end

   // token entering the head of the row
   always_comb begin
      tok[0]             = '0;
      tok[0].live        = scan_go;
      tok[0].is_find     = req_in.opcode == OP_FIND;
      tok[0].position    = req_in.position;
      tok[0].index       = req_in.index;
      tok[0].found_index = NONE_INDEX;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_acc && !scan_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (tail.live) begin
         rsp_valid_in          = 1'b1;
         rsp_in.found_index    = tail.found_index;
         rsp_in.start_position = tail.lo;
         rsp_in.end_position   = tail.hi;
         rsp_in.interval_speed = tail.spd;
         rsp_in.status         = tail.hit ? STAT_OK : STAT_MISS;
      end else if (rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (scan_go) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tail.live) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_in.ready           = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_out.ready);
      rsp_out.valid          = rsp_valid_ff;
      rsp_out.found_index    = rsp_ff.found_index;
      rsp_out.start_position = rsp_ff.start_position;
      rsp_out.end_position   = rsp_ff.end_position;
      rsp_out.interval_speed = rsp_ff.interval_speed;
      rsp_out.status         = rsp_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         run_start_ff <= '0;
         run_speed_ff <= '0;
         prev_pos_ff  <= '0;
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_start_ff <= run_start_in;
         run_speed_ff <= run_speed_in;
         prev_pos_ff  <= prev_pos_in;
         run_open_ff  <= run_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> state_ff == S_SCAN)
      else $error("token left the row outside a scan");

   a_tail_slot_free: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> !rsp_valid_ff)
      else $error("scan result arrived while the response register was occupied");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_INTERVALS))
      else $error("interval count beyond table size");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      scan_go |=> state_ff == S_SCAN && !rsp_valid_ff)
      else $error("scan did not block the request side");
`endif

endmodule

// File: rtl/sim_cell.sv
// One cell of the interval row: holds one stored interval and passes the
// lookup token on to its neighbour each cycle. Depends on sim_pkg.
`timescale 1ns / 1ps

module sim_cell #(
   parameter int CELL_ID = 0,
   parameter int COUNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sim_pkg::wr_type      wr_i,
   input  logic [COUNT_W-1:0]   count_i,
   input  sim_pkg::tok_type     tok_i,
   output sim_pkg::tok_type     tok_o
);
   import sim_pkg::*;

   logic [POS_W-1:0] lo_ff;
   logic [POS_W-1:0] hi_ff;
   logic [SPD_W-1:0] spd_ff;
   logic             live_ff;
   logic             live_in;
   tok_type          tok_ff;
   tok_type          tok_in;
   logic             held;
   logic             hit_here;

   always_ff @(posedge clock) begin
      if (wr_i.we && wr_i.addr == IDX_W'(CELL_ID)) begin
         lo_ff  <= wr_i.lo;
         hi_ff  <= wr_i.hi;
         spd_ff <= wr_i.spd;
      end
   end

   always_comb begin
      held     = COUNT_W'(CELL_ID) < count_i;
      hit_here = tok_i.live && !tok_i.hit && held &&
                 (tok_i.is_find ? (lo_ff <= tok_i.position && tok_i.position <= hi_ff)
                                : (tok_i.index == IDX_W'(CELL_ID)));
      tok_in   = tok_i;
      live_in  = tok_i.live;
      if (hit_here) begin
         tok_in.hit         = 1'b1;
         tok_in.found_index = IDX_W'(CELL_ID);
         tok_in.lo          = lo_ff;
         tok_in.hi          = hi_ff;
         tok_in.spd         = spd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   always_comb begin
      tok_o      = tok_ff;
      tok_o.live = live_ff;
   end

endmodule

// File: dv/speed_interval_map_tb.sv
// Self-checking testbench for speed_interval_map: a directed script, then random words,
// checked against an in-bench model of the interval table. Uses sim_pkg and sim_chan_if.
`timescale 1ns / 1ps

module speed_interval_map_tb;
   import sim_pkg::*;

   localparam int MAX_SPANS     = 64;
   localparam int RANDOM_WORDS  = 900;
   localparam int QUIET_TAIL    = 150;
   localparam int STALL_LIMIT   = 4000;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [SPD_W-1:0] spd;
      logic [IDX_W-1:0] idx;
      logic             fixed;
      rsp_type          want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   sim_req_if req_bus ();
   sim_rsp_if rsp_bus ();

   speed_interval_map #(.MAX_INTERVALS(MAX_SPANS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus)
   );

   always #2 clock = ~clock;

   // interval table model
   logic [POS_W-1:0] span_lo  [MAX_SPANS];
   logic [POS_W-1:0] span_hi  [MAX_SPANS];
   logic [SPD_W-1:0] span_spd [MAX_SPANS];
   int               stored_count = 0;
   logic [POS_W-1:0] run_lo       = '0;
   logic [SPD_W-1:0] run_spd      = '0;
   logic [POS_W-1:0] last_pos     = '0;
   logic             run_live     = 1'b0;

   rsp_type          pending_rsps [$];
   script_row_type   script [$];
   logic [SPD_W-1:0] speed_pool [4];
   int               mismatch_count = 0;
   bit               idle_on = 1'b1;
   int               rsp_stall = 0;
   int               quiet_cycles = 0;
   rsp_type          seen;
   rsp_type          want;

   function automatic rsp_type make_rsp(input logic [IDX_W-1:0] fi, input logic [POS_W-1:0] lo,
                                        input logic [POS_W-1:0] hi, input logic [SPD_W-1:0] spd,
                                        input logic [STAT_W-1:0] st);
      rsp_type r;
      r.found_index    = fi;
      r.start_position = lo;
      r.end_position   = hi;
      r.interval_speed = spd;
      r.status         = st;
      return r;
   endfunction

   function automatic rsp_type span_rsp(input int k);
      return make_rsp(k[IDX_W-1:0], span_lo[k], span_hi[k], span_spd[k], STAT_OK);
   endfunction

   function automatic rsp_type store_open_run();
      int k;
      if (stored_count < MAX_SPANS) begin
         k = stored_count;
         span_lo[k]  = run_lo;
         span_hi[k]  = last_pos;
         span_spd[k] = run_spd;
         stored_count = k + 1;
         return span_rsp(k);
      end
      return make_rsp(NONE_INDEX, '0, '0, '0, STAT_FULL);
   endfunction

   function automatic rsp_type predict_interval_rsp(input logic [OP_W-1:0] op,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [SPD_W-1:0] spd,
                                                    input logic [IDX_W-1:0] idx);
      rsp_type r;
      r = make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS);
      case (op)
         OP_CLEAR: begin
            stored_count = 0;
            run_live = 1'b0;
            r.status = STAT_OK;
         end
         OP_ADD: begin
            if (run_live && spd != run_spd) begin
               r = store_open_run();
               run_lo  = pos;
               run_spd = spd;
            end else begin
               if (!run_live) begin
                  run_lo   = pos;
                  run_spd  = spd;
                  run_live = 1'b1;
               end
               r.status = STAT_OK;
            end
            last_pos = pos;
         end
         OP_CLOSE: begin
            if (run_live) begin
               r = store_open_run();
               run_live = 1'b0;
            end
         end
         OP_FIND: begin
            for (int i = 0; i < stored_count; i++) begin
               if (pos >= span_lo[i] && pos <= span_hi[i]) begin
                  r = span_rsp(i);
                  break;
               end
            end
         end
         OP_READ: begin
            if (int'(idx) < stored_count) r = span_rsp(int'(idx));
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input rsp_type got, input rsp_type exp_val);
      $display("%0t ns: mismatch on %s, got %h, want %h", $realtime, what, got, exp_val);
      mismatch_count++;
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [SPD_W-1:0] spd, input logic [IDX_W-1:0] idx,
                          input logic fixed, input rsp_type w);
      script_row_type row;
      row.op    = op;
      row.pos   = pos;
      row.spd   = spd;
      row.idx   = idx;
      row.fixed = fixed;
      row.want  = w;
      script = {script, row};
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [SPD_W-1:0] spd, input logic [IDX_W-1:0] idx,
                            input logic fixed, input rsp_type w);
      rsp_type predicted;
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.position    <= pos;
      req_bus.speed_limit <= spd;
      req_bus.index       <= idx;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_interval_rsp(op, pos, spd, idx);
      if (fixed) predicted = w;
      pending_rsps = {pending_rsps, predicted};
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // response side: check, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = make_rsp(rsp_bus.found_index, rsp_bus.start_position, rsp_bus.end_position,
                         rsp_bus.interval_speed, rsp_bus.status);
         if (pending_rsps.size() == 0) begin
            flag_mismatch("unexpected word", seen, '0);
         end else begin
            want = pending_rsps.pop_front();
            if (seen !== want)
               flag_mismatch("response word", seen, want);
         end
      end
      if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idle_on && $urandom_range(0, 4) == 0) rsp_stall = $urandom_range(1, 17);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("speed_interval_map test failed");
         $finish;
      end
   end

   initial begin
      int pick;
      int k;
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [SPD_W-1:0] spd;
      logic [IDX_W-1:0] idx;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_CLEAR;
      req_bus.position    = '0;
      req_bus.speed_limit = '0;
      req_bus.index       = '0;
      rsp_bus.ready       = 1'b0;
      foreach (speed_pool[j]) speed_pool[j] = SPD_W'($urandom);

      add_row(OP_READ,     '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_CLOSE,    '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_FIND,     '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_SPARE_LO, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_SPARE_HI, '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_ADD,      '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_OK));
      add_row(OP_ADD,      24'd100,   '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_OK));
      add_row(OP_ADD,      24'hFFFFFF, 16'hFFFF, '0,  1'b1,
              make_rsp(8'd0, '0, 24'd100, '0, STAT_OK));
      add_row(OP_ADD,      24'd50,    16'd1,    '0,   1'b1,
              make_rsp(8'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, STAT_OK));
      add_row(OP_CLOSE,    '0,        '0,       '0,   1'b1,
              make_rsp(8'd2, 24'd50, 24'd50, 16'd1, STAT_OK));
      add_row(OP_FIND,     24'hFFFFFF, '0,      '0,   1'b0, '0);
      add_row(OP_FIND,     '0,        '0,       '0,   1'b0, '0);
      add_row(OP_FIND,     24'd101,   '0,       '0,   1'b0, '0);
      add_row(OP_READ,     '0,        '0,       8'hFF, 1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_READ,     '0,        '0,       8'd2, 1'b0, '0);
      add_row(OP_ADD,      24'd500,   16'd7,    '0,   1'b0, '0);
      add_row(OP_ADD,      24'd400,   16'd7,    '0,   1'b0, '0);
      add_row(OP_ADD,      24'd600,   16'd8,    '0,   1'b0, '0);
      add_row(OP_FIND,     24'd450,   '0,       '0,   1'b0, '0);
      add_row(OP_CLOSE,    '0,        '0,       '0,   1'b0, '0);
      add_row(OP_CLEAR,    '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_OK));
      add_row(OP_READ,     '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_CLOSE,    '0,        '0,       '0,   1'b1,
              make_rsp(NONE_INDEX, '0, '0, '0, STAT_MISS));
      add_row(OP_ADD,      24'd12345, 16'hAAAA, 8'h55, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r])
         send_word(script[r].op, script[r].pos, script[r].spd, script[r].idx,
                   script[r].fixed, script[r].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         idle_on = (n < RANDOM_WORDS - QUIET_TAIL) && ((n % 200) < 150);
         if (n == RANDOM_WORDS / 2) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_rsps.size() != 0);
         end
         pick = $urandom_range(0, 199);
         pos  = POS_W'($urandom);
         spd  = SPD_W'($urandom);
         idx  = IDX_W'($urandom);
         if (pick == 0) begin
            op = OP_CLEAR;
         end else if (pick < 4) begin
            op = OP_SPARE_LO + OP_W'($urandom_range(0, 2));
         end else if (pick < 120) begin
            op = OP_ADD;
            if ($urandom_range(0, 9) != 0) pos = last_pos + POS_W'($urandom_range(0, 2000));
            if ($urandom_range(0, 49) == 0)
               speed_pool[2'($urandom_range(0, 3))] = SPD_W'($urandom);
            spd = speed_pool[2'($urandom_range(0, 3))];
         end else if (pick < 140) begin
            op = OP_CLOSE;
         end else if (pick < 170) begin
            op = OP_FIND;
            if (stored_count > 0 && $urandom_range(0, 4) != 0) begin
               k = $urandom_range(0, stored_count - 1);
               pos = (span_lo[k] <= span_hi[k]) ?
                     POS_W'($urandom_range(span_lo[k], span_hi[k])) : span_lo[k];
            end
         end else begin
            op = OP_READ;
            if (stored_count > 0 && $urandom_range(0, 4) != 0)
               idx = IDX_W'($urandom_range(0, stored_count - 1));
         end
         send_word(op, pos, spd, idx, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (2 * MAX_SPANS) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("speed_interval_map test passed");
      end else begin
         $display("speed_interval_map test failed");
      end
      $finish;
   end

endmodule
